@@ rtl/core/epdq_pkg.sv @@
// ----------------------------------------------------------------------------
// epdq_pkg
// Shared constants of the RGB565 e-paper palette quantizer: mode codes,
// luma weights and the tricolor palette.
// ----------------------------------------------------------------------------
package epdq_pkg;

  localparam int unsigned ModeW   = 2;
  localparam int unsigned PixelW  = 16;
  localparam int unsigned IndexW  = 2;
  localparam int unsigned LumaW   = 16;
  localparam int unsigned SqW     = 12;
  localparam int unsigned DistW   = 14;
  localparam int unsigned NumTri  = 3;

  localparam logic [ModeW-1:0] MODE_MONO = 2'd0;
  localparam logic [ModeW-1:0] MODE_GRAY = 2'd1;
  localparam logic [ModeW-1:0] MODE_TRI  = 2'd2;

  localparam logic [IndexW-1:0] IDX_BLACK = 2'd0;
  localparam logic [IndexW-1:0] IDX_WHITE = 2'd1;
  localparam logic [IndexW-1:0] IDX_RED   = 2'd2;
  localparam logic [IndexW-1:0] IDX_NONE  = 2'd3;

  localparam logic [LumaW-1:0] LUMA_WR = 16'd631;
  localparam logic [LumaW-1:0] LUMA_WG = 16'd611;
  localparam logic [LumaW-1:0] LUMA_WB = 16'd241;

  typedef logic [5:0] chan_t;
  typedef chan_t      pal_t [NumTri];

  // Palette in RGB565 channel units: black, white, red.
  localparam pal_t PAL_R = '{6'(47 >> 3), 6'(242 >> 3), 6'(215 >> 3)};
  localparam pal_t PAL_G = '{6'(36 >> 2), 6'(244 >> 2), 6'(38 >> 2)};
  localparam pal_t PAL_B = '{6'(41 >> 3), 6'(239 >> 3), 6'(39 >> 3)};

endpackage

@@ rtl/core/rgb565_epd_palette_quantizer.sv @@
// ----------------------------------------------------------------------------
// rgb565_epd_palette_quantizer
// Maps one RGB565 pixel to an e-paper palette index: luma threshold for
// mono, two luma bits for grayscale, nearest color for tricolor.
// ----------------------------------------------------------------------------
// Channel  Direction  Ports                            Carries
// in       sink       in_valid/in_ready                in_pixel_rgb565
// out      source     out_valid/out_ready              out_palette_index
// cfg      sink       cfg_valid/cfg_ready              cfg_display_mode
//
// Four register stages: capture, products and squares, sums, select.
// One request enters per cycle unless a stall holds the pipeline. An
// accepted request passes the stages in order, from capture to select.
// Synchronous active-low reset empties all stages and sets mono mode.
// A stalled stage holds its request; earlier stages fill their gaps.
// ----------------------------------------------------------------------------
module rgb565_epd_palette_quantizer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [epdq_pkg::PixelW-1:0]   in_pixel_rgb565,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [epdq_pkg::IndexW-1:0]   out_palette_index,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [epdq_pkg::ModeW-1:0]    cfg_display_mode
);
  import epdq_pkg::*;

  logic [ModeW-1:0] mode_r;

  logic               v1_r, v2_r, v3_r, v4_r;
  logic               rdy1, rdy2, rdy3, rdy4;
  logic [PixelW-1:0]  px1_r;
  logic [ModeW-1:0]   mode1_r, mode2_r, mode3_r;
  logic [14:0]        lr2_r;
  logic [15:0]        lg2_r;
  logic [12:0]        lb2_r;
  logic [SqW-1:0]     sqr2_r [NumTri];
  logic [SqW-1:0]     sqg2_r [NumTri];
  logic [SqW-1:0]     sqb2_r [NumTri];
  logic [SqW-1:0]     sqr_nxt [NumTri];
  logic [SqW-1:0]     sqg_nxt [NumTri];
  logic [SqW-1:0]     sqb_nxt [NumTri];
  logic [LumaW-1:0]   luma3_r;
  logic [DistW-1:0]   dist3_r [NumTri];
  logic [IndexW-1:0   ] idx4_r;
  logic [IndexW-1:0]  idx_nxt;
  logic [4:0]         r1, b1;
  logic [5:0]         g1;
  logic [16:0]        luma_sum;

  assign cfg_ready = 1'b1;

  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  assign out_valid         = v4_r;
  assign out_palette_index = idx4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_MONO;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_display_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy4) begin
        v4_r <= v3_r;
      end
    end
  end

  // Stage 1: capture.
  always_ff @(posedge clk) begin
    if (rdy1) begin
      px1_r   <= in_pixel_rgb565;
      mode1_r <= mode_r;
    end
  end

  // Stage 2: luma products and squared differences, red and blue doubled.
  assign r1 = px1_r[15:11];
  assign g1 = px1_r[10:5];
  assign b1 = px1_r[4:0];

  always_comb begin
    logic signed [7:0]  dr, dg, db;
    logic signed [15:0] pr, pg, pb;
    for (int i = 0; i < NumTri; i++) begin
      dr = ($signed({3'b000, r1}) - $signed({2'b00, PAL_R[i]})) <<< 1;
      dg =  $signed({2'b00, g1})  - $signed({2'b00, PAL_G[i]});
      db = ($signed({3'b000, b1}) - $signed({2'b00, PAL_B[i]})) <<< 1;
      pr = dr * dr;
      pg = dg * dg;
      pb = db * db;
      sqr_nxt[i] = pr[SqW-1:0];
      sqg_nxt[i] = pg[SqW-1:0];
      sqb_nxt[i] = pb[SqW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      mode2_r <= mode1_r;
      lr2_r   <= 15'(r1 * LUMA_WR);
      lg2_r   <= 16'(g1 * LUMA_WG);
      lb2_r   <= 13'(b1 * LUMA_WB);
      for (int i = 0; i < NumTri; i++) begin
        sqr2_r[i] <= sqr_nxt[i];
        sqg2_r[i] <= sqg_nxt[i];
        sqb2_r[i] <= sqb_nxt[i];
      end
    end
  end

  // Stage 3: sums.
  assign luma_sum = {2'b00, lr2_r} + {1'b0, lg2_r} + {4'b0000, lb2_r};

  always_ff @(posedge clk) begin
    if (rdy3) begin
      mode3_r <= mode2_r;
      luma3_r <= luma_sum[LumaW-1:0];
      for (int i = 0; i < NumTri; i++) begin
        dist3_r[i] <= {2'b00, sqr2_r[i]} + {2'b00, sqg2_r[i]} + {2'b00, sqb2_r[i]};
      end
    end
  end

  // Stage 4: select; ties keep the lower index.
  always_comb begin
    logic [DistW-1:0] best;
    logic [IndexW-1:0] tri_idx;
    best    = dist3_r[0];
    tri_idx = IDX_BLACK;
    if (dist3_r[1] < best) begin
      best    = dist3_r[1];
      tri_idx = IDX_WHITE;
    end
    if (dist3_r[2] < best) begin
      tri_idx = IDX_RED;
    end
    case (mode3_r)
      MODE_MONO: idx_nxt = {1'b0, luma3_r[15]};
      MODE_GRAY: idx_nxt = luma3_r[15:14];
      default:   idx_nxt = tri_idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      idx4_r <= idx_nxt;
    end
  end

  a_tri_no_three: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && rdy4 && mode3_r != MODE_MONO && mode3_r != MODE_GRAY)
      |=> (idx4_r != IDX_NONE))
    else $error("tricolor selection produced an unused index");

  a_mono_one_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && rdy4 && mode3_r == MODE_MONO) |=> (idx4_r[1] == 1'b0))
    else $error("mono selection produced more than one bit");

  a_stage1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !rdy2) |=> (v1_r && $stable(px1_r) && $stable(mode1_r)))
    else $error("stalled stage one lost its request");

  a_stage3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !rdy4) |=> (v3_r && $stable(luma3_r) && $stable(mode3_r)))
    else $error("stalled stage three lost its request");

  a_mode_write_only: assert property (@(posedge clk) disable iff (!rst_n)
    !(cfg_valid && cfg_ready) |=> $stable(mode_r))
    else $error("mode changed without a configuration write");

endmodule
